>>> sv/acbt_pkg.sv
// Shared types and constants of the alpha crop box tracker.
// No dependencies; every other file but acbt_fifo refers to it by scoped names.
package acbt_pkg;

    // largest frame side; bigger register values are held at this
    localparam int MAX_DIM  = 4096;

    localparam int DIM_W    = 13;  // frame size registers
    localparam int XY_W     = 13;  // internal column / row coordinates
    localparam int THR_W    = 8;
    localparam int PAD_W    = 12;
    localparam int ALPHA_W  = 8;
    localparam int OUT_XY_W = 12;
    localparam int OUT_WH_W = 13;
    localparam int IDX_W    = 2;

    typedef logic [IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_FRAME_WIDTH     = 2'd0;
    localparam t_reg_idx REG_FRAME_HEIGHT    = 2'd1;
    localparam t_reg_idx REG_ALPHA_THRESHOLD = 2'd2;
    localparam t_reg_idx REG_PAD_AMOUNT      = 2'd3;

    // effective frame size, already limited to 1..MAX_DIM
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_frame;

    // raw box of one pass, handed from the front to the back
    typedef struct packed {
        logic            hit;
        logic [XY_W-1:0] min_x;
        logic [XY_W-1:0] max_x;
        logic [XY_W-1:0] min_y;
        logic [XY_W-1:0] max_y;
    } t_box;

    typedef struct packed {
        logic [OUT_XY_W-1:0] crop_x;
        logic [OUT_XY_W-1:0] crop_y;
        logic [OUT_WH_W-1:0] crop_w;
        logic [OUT_WH_W-1:0] crop_h;
        logic                found;
    } t_res;

endpackage

>>> sv/acbt_fifo.sv
// Small synchronous FIFO with occupancy count.
// Used for the box queue and the result queue; no package dependency.
module acbt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [W-1:0]                 i_din,
    input  logic                         i_rd,
    output logic [W-1:0]                 o_dout,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_ok;
    logic          rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_dout  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (rd_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> sv/acbt_front.sv
// Front end: raster counters, threshold test and running box tracking.
// Emits one acbt_pkg::t_box per pass; depends on acbt_pkg.
module acbt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acbt_pkg::t_frame              i_frame,
    input  logic [acbt_pkg::THR_W-1:0]    i_thr,
    input  logic                          i_accept,
    input  logic [acbt_pkg::ALPHA_W-1:0]  i_alpha,
    input  logic                          i_last,
    output logic                          o_box_wr,
    output acbt_pkg::t_box                o_box
);

    localparam int XW = acbt_pkg::XY_W;

    logic [XW-1:0] r_col, r_row, r_min_x, r_max_x, r_min_y, r_max_y;
    logic          r_any;
    logic [XW-1:0] n_col, n_row, n_min_x, n_max_x, n_min_y, n_max_y;
    logic          n_any;
    logic [XW-1:0] col, row, col_inc, row_inc;
    logic          hit;

    always_comb begin
        col     = (r_col >= i_frame.w) ? '0 : r_col;
        row     = (r_row >= i_frame.h) ? '0 : r_row;
        col_inc = col + XW'(1);
        row_inc = row + XW'(1);
        hit     = (i_alpha > i_thr);

        n_min_x = r_min_x;
        n_max_x = r_max_x;
        n_min_y = r_min_y;
        n_max_y = r_max_y;
        n_any   = r_any;
        if (hit) begin
            n_any = 1'b1;
            if (!r_any) begin
                n_min_x = col;
                n_max_x = col;
                n_min_y = row;
                n_max_y = row;
            end else begin
                if (col < r_min_x) n_min_x = col;
                if (col > r_max_x) n_max_x = col;
                if (row < r_min_y) n_min_y = row;
                if (row > r_max_y) n_max_y = row;
            end
        end

        if (col_inc >= i_frame.w) begin
            n_col = '0;
            n_row = (row_inc >= i_frame.h) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = row;
        end

        o_box.hit   = n_any;
        o_box.min_x = n_min_x;
        o_box.max_x = n_max_x;
        o_box.min_y = n_min_y;
        o_box.max_y = n_max_y;
        o_box_wr    = i_accept && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            // clear tracking at reset and after the pass is handed off
            r_col   <= '0;
            r_row   <= '0;
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_any   <= 1'b0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_min_x <= n_min_x;
            r_max_x <= n_max_x;
            r_min_y <= n_min_y;
            r_max_y <= n_max_y;
            r_any   <= n_any;
        end
    end

endmodule

>>> sv/acbt_back.sv
// Back end: pads, clamps and evens a queued box over two steps, then
// queues the result. Depends on acbt_pkg and acbt_fifo.
module acbt_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  acbt_pkg::t_frame            i_frame,
    input  logic [acbt_pkg::PAD_W-1:0]  i_pad,
    input  logic                        i_box_valid,
    input  acbt_pkg::t_box              i_box,
    output logic                        o_box_rd,
    input  logic                        i_pop,
    output acbt_pkg::t_res              o_res,
    output logic                        o_empty
);

    localparam int XW = acbt_pkg::XY_W;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [XW-1:0] s;
        logic [XW-1:0] e;
    } t_span;

    typedef struct packed {
        logic [XW-1:0] start;
        logic [XW-1:0] len;
    } t_axis;

    // clamp the raw span into the frame and grow it by the padding
    function automatic t_span pad_span(input logic [XW-1:0] lo, input logic [XW-1:0] hi,
                                       input logic [XW-1:0] lim,
                                       input logic [acbt_pkg::PAD_W-1:0] pad);
        logic [XW-1:0] top;
        logic [XW-1:0] lo_c;
        logic [XW-1:0] hi_c;
        logic [XW-1:0] pad_x;
        logic [XW:0]   e_raw;
        t_span         sp;
        top   = lim - XW'(1);
        lo_c  = (lo > top) ? top : lo;
        hi_c  = (hi > top) ? top : hi;
        pad_x = XW'(pad);
        if (hi_c < lo_c) hi_c = lo_c;
        sp.s  = (lo_c > pad_x) ? lo_c - pad_x : '0;
        e_raw = {1'b0, hi_c} + (XW+1)'(1) + {1'b0, pad_x};
        sp.e  = (e_raw > {1'b0, lim}) ? lim : e_raw[XW-1:0];
        return sp;
    endfunction

    // make the length even where possible, then at least 2
    function automatic t_axis even_axis(input t_span sp, input logic [XW-1:0] lim);
        t_axis ax;
        ax.start = sp.s;
        ax.len   = sp.e - sp.s;
        if (ax.len[0]) begin
            if (sp.e < lim) begin
                ax.len = ax.len + XW'(1);
            end else if (sp.s != '0) begin
                ax.start = sp.s - XW'(1);
                ax.len   = ax.len + XW'(1);
            end
        end
        if (ax.len < XW'(2)) ax.len = XW'(2);
        return ax;
    endfunction

    logic          r_s1_v;
    logic          r_s1_hit;
    t_span         r_s1_x;
    t_span         r_s1_y;
    t_span         n_s1_x;
    t_span         n_s1_y;
    t_axis         ax_x;
    t_axis         ax_y;
    acbt_pkg::t_res res;
    logic [CW-1:0] out_cnt;
    logic          out_full;
    logic [$bits(acbt_pkg::t_res)-1:0] out_dout;

    // take a box only when the result queue has room for everything in flight
    assign o_box_rd = i_box_valid && ((32'(out_cnt) + 32'(r_s1_v)) < OUT_DEPTH);

    assign n_s1_x = pad_span(i_box.min_x, i_box.max_x, i_frame.w, i_pad);
    assign n_s1_y = pad_span(i_box.min_y, i_box.max_y, i_frame.h, i_pad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= o_box_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_box_rd) begin
            r_s1_hit <= i_box.hit;
            r_s1_x   <= n_s1_x;
            r_s1_y   <= n_s1_y;
        end
    end

    always_comb begin
        ax_x = even_axis(r_s1_x, i_frame.w);
        ax_y = even_axis(r_s1_y, i_frame.h);
        if (r_s1_hit) begin
            res.crop_x = ax_x.start[acbt_pkg::OUT_XY_W-1:0];
            res.crop_y = ax_y.start[acbt_pkg::OUT_XY_W-1:0];
            res.crop_w = acbt_pkg::OUT_WH_W'(ax_x.len);
            res.crop_h = acbt_pkg::OUT_WH_W'(ax_y.len);
            res.found  = 1'b1;
        end else begin
            res.crop_x = '0;
            res.crop_y = '0;
            res.crop_w = acbt_pkg::OUT_WH_W'(i_frame.w);
            res.crop_h = acbt_pkg::OUT_WH_W'(i_frame.h);
            res.found  = 1'b0;
        end
    end

    acbt_fifo #(
        .W     ($bits(acbt_pkg::t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_s1_v),
        .i_din   (res),
        .i_rd    (i_pop),
        .o_dout  (out_dout),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_cnt)
    );

    assign o_res = acbt_pkg::t_res'(out_dout);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> !out_full)
        else $error("result queue written while full");

endmodule

>>> sv/alpha_crop_box_tracker_unit.sv
// Top level of the alpha crop box tracker: configuration registers,
// front end, box queue and back end. Depends on acbt_pkg and all acbt_ modules.
//
// Pixel channel: an item (i_alpha, i_last_of_pass) is taken at a clock edge
// with push high and full low. One pixel per clock is taken while full is low;
// full rises only when the box queue (two entries) is filled with passes that the
// back end has not yet taken.
// Result channel: a box is on o_crop_* / o_found while empty is low and is
// taken at an edge with pop high. Only the pixel marked last of pass makes
// a result; it passes through the box queue and the pad stage into the
// result queue. The back end finishes one box per cycle while the result
// queue has room, set by its single pad stage.
// Stalls: while pop is held low, up to four results wait in the result
// queue, then boxes wait in the box queue; pixels keep flowing until that
// queue is full.
// Reset (i_rst_n low, synchronous) loads the default registers
// (2048 x 2048, threshold 1, padding 10) and empties all queues and
// tracking state. Write configuration only while no pass is in flight.
module alpha_crop_box_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [acbt_pkg::ALPHA_W-1:0]        i_alpha,
    input  logic                                i_last_of_pass,
    output logic                                empty,
    input  logic                                pop,
    output logic [acbt_pkg::OUT_XY_W-1:0]       o_crop_x,
    output logic [acbt_pkg::OUT_XY_W-1:0]       o_crop_y,
    output logic [acbt_pkg::OUT_WH_W-1:0]       o_crop_w,
    output logic [acbt_pkg::OUT_WH_W-1:0]       o_crop_h,
    output logic                                o_found,
    input  logic                                i_cfg_we,
    input  acbt_pkg::t_reg_idx                  i_cfg_idx,
    input  logic [acbt_pkg::DIM_W-1:0]          i_cfg_data
);

    localparam int DW      = acbt_pkg::DIM_W;
    localparam int DIM_CAP = (acbt_pkg::MAX_DIM > (2 ** DW) - 1) ? (2 ** DW) - 1
                                                                 : acbt_pkg::MAX_DIM;
    localparam logic [DW-1:0] CAP_V = DW'(DIM_CAP);
    localparam int BOX_W   = $bits(acbt_pkg::t_box);

    logic [DW-1:0]                  r_frame_w;
    logic [DW-1:0]                  r_frame_h;
    logic [acbt_pkg::THR_W-1:0]     r_thr;
    logic [acbt_pkg::PAD_W-1:0]     r_pad;

    acbt_pkg::t_frame               frame;
    acbt_pkg::t_box                 box_in;
    acbt_pkg::t_box                 box_out;
    acbt_pkg::t_res                 res;
    logic [BOX_W-1:0]               box_dout;
    logic                           accept;
    logic                           box_wr;
    logic                           box_rd;
    logic                           box_empty;
    logic [1:0]                     box_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= DW'(2048);
            r_frame_h <= DW'(2048);
            r_thr     <= acbt_pkg::THR_W'(1);
            r_pad     <= acbt_pkg::PAD_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acbt_pkg::REG_FRAME_WIDTH:     r_frame_w <= i_cfg_data;
                acbt_pkg::REG_FRAME_HEIGHT:    r_frame_h <= i_cfg_data;
                acbt_pkg::REG_ALPHA_THRESHOLD: r_thr <= i_cfg_data[acbt_pkg::THR_W-1:0];
                acbt_pkg::REG_PAD_AMOUNT:      r_pad <= i_cfg_data[acbt_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, oversize is held at the maximum
    always_comb begin
        frame.w = (r_frame_w == '0) ? DW'(1) : ((r_frame_w > CAP_V) ? CAP_V : r_frame_w);
        frame.h = (r_frame_h == '0) ? DW'(1) : ((r_frame_h > CAP_V) ? CAP_V : r_frame_h);
    end

    assign accept = push && !full;

    acbt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame),
        .i_thr    (r_thr),
        .i_accept (accept),
        .i_alpha  (i_alpha),
        .i_last   (i_last_of_pass),
        .o_box_wr (box_wr),
        .o_box    (box_in)
    );

    acbt_fifo #(
        .W     (BOX_W),
        .DEPTH (2)
    ) u_box_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (box_wr),
        .i_din   (box_in),
        .i_rd    (box_rd),
        .o_dout  (box_dout),
        .o_full  (full),
        .o_empty (box_empty),
        .o_count (box_cnt)
    );

    assign box_out = acbt_pkg::t_box'(box_dout);

    acbt_back #(
        .OUT_DEPTH (4)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame),
        .i_pad       (r_pad),
        .i_box_valid (!box_empty),
        .i_box       (box_out),
        .o_box_rd    (box_rd),
        .i_pop       (pop),
        .o_res       (res),
        .o_empty     (empty)
    );

    assign o_crop_x = res.crop_x;
    assign o_crop_y = res.crop_y;
    assign o_crop_w = res.crop_w;
    assign o_crop_h = res.crop_h;
    assign o_found  = res.found;

    a_last_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_of_pass) |=> !box_empty)
        else $error("accepted end of pass did not reach the box queue");

    a_no_spurious_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && i_last_of_pass) |=> (box_cnt <= $past(box_cnt)))
        else $error("box queue grew without an end of pass");

    a_rd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        box_rd |-> !box_empty)
        else $error("back end took a box from an empty queue");

endmodule
